// ===== rtl/core/bpc_pkg.sv =====
package bpc_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_TEMP_COEFF  = 2'd0,
        CFG_PRESS_COEFF = 2'd1,
        CFG_CURVE_COEFF = 2'd2,
        CFG_OSS         = 2'd3
    } cfg_index_t;

    // quotient bits of the b5 divider: |mc * 2048| <= 2^26
    localparam int unsigned DIV1_STEPS = 27;
    // quotient bits of the pressure divider
    localparam int unsigned DIV2_STEPS = 32;
    // register stages from an accepted item to its result strobe
    localparam int unsigned LATENCY    = 17 + DIV1_STEPS + DIV2_STEPS;

    localparam logic [1:0]  OSS_RESET   = 2'd1;
    localparam logic [31:0] T_ROUND     = 32'd8;
    localparam logic [31:0] B6_OFFSET   = 32'd4000;
    localparam logic [31:0] C_BIAS      = 32'd32768;
    localparam logic [31:0] B7_SCALE    = 32'd50000;
    localparam logic [31:0] P_SQ_COEF   = 32'd3038;
    localparam logic [31:0] P_LIN_COEF  = 32'hFFFF_E343;   // -7357
    localparam logic [31:0] P_OFFSET    = 32'd3791;

    // arithmetic shift right of a 32-bit word
    function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
        return 32'($signed(x) >>> n);
    endfunction

endpackage

// ===== rtl/core/barometric_pressure_compensation.sv =====
// channel   direction  transfer when        payload
// -------   ---------  -------------------  ------------------------------------------
// input     in         start && !busy       raw_temperature, raw_pressure
// result    out        done (one cycle)     pressure_pa, temperature_tenths, divide_fault
// config    in         cfg_write            cfg_index, cfg_data
//
// one reading pair may enter every cycle; busy is never raised
// each result runs through the two bit-per-stage dividers (27 and 32 stages)
// plus 17 arithmetic stages between its input transfer and its result strobe
// rst_n clears the valid chain and coefficients, oss resets to OSS_RESET, data stages are not reset
// the receiver cannot stall, so the pipeline never holds
module barometric_pressure_compensation
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] raw_temperature,
    input  logic [18:0] raw_pressure,
    output logic        done,
    output logic [31:0] pressure_pa,
    output logic [31:0] temperature_tenths,
    output logic        divide_fault,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int unsigned D1 = bpc_pkg::DIV1_STEPS;
    localparam int unsigned D2 = bpc_pkg::DIV2_STEPS;
    localparam int unsigned LAT = bpc_pkg::LATENCY;
    // valid chain positions of the divider entry stages
    localparam int unsigned ST_C = 3;
    localparam int unsigned ST_L = ST_C + D1 + 9;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [63:0] temp_coeff_reg;
    logic [63:0] press_coeff_reg;
    logic [31:0] curve_coeff_reg;
    logic [1:0]  oss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeff_reg  <= '0;
            press_coeff_reg <= '0;
            curve_coeff_reg <= '0;
            oss_reg         <= bpc_pkg::OSS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bpc_pkg::CFG_TEMP_COEFF:  temp_coeff_reg  <= cfg_data;
                bpc_pkg::CFG_PRESS_COEFF: press_coeff_reg <= cfg_data;
                bpc_pkg::CFG_CURVE_COEFF: curve_coeff_reg <= cfg_data[31:0];
                bpc_pkg::CFG_OSS:         oss_reg         <= cfg_data[1:0];
                default:                  oss_reg         <= oss_reg;
            endcase
        end
    end

    // unpacked coefficients, signed ones extended to a word
    logic [31:0] ac5_w, ac6_w, ac4_w;
    logic [31:0] mc_w, md_w, ac1_w, ac2_w, ac3_w, b1_w, b2_w;

    assign ac5_w = {16'd0, temp_coeff_reg[63:48]};
    assign ac6_w = {16'd0, temp_coeff_reg[47:32]};
    assign mc_w  = {{16{temp_coeff_reg[31]}}, temp_coeff_reg[31:16]};
    assign md_w  = {{16{temp_coeff_reg[15]}}, temp_coeff_reg[15:0]};
    assign ac1_w = {{16{press_coeff_reg[63]}}, press_coeff_reg[63:48]};
    assign ac2_w = {{16{press_coeff_reg[47]}}, press_coeff_reg[47:32]};
    assign ac3_w = {{16{press_coeff_reg[31]}}, press_coeff_reg[31:16]};
    assign ac4_w = {16'd0, press_coeff_reg[15:0]};
    assign b1_w  = {{16{curve_coeff_reg[31]}}, curve_coeff_reg[31:16]};
    assign b2_w  = {{16{curve_coeff_reg[15]}}, curve_coeff_reg[15:0]};

    // ------------------------------------------------------------------
    // valid chain, one bit per stage
    // ------------------------------------------------------------------
    logic [LAT-1:0] vld_reg;
    logic           accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], accept};
        end
    end

    // ------------------------------------------------------------------
    // temperature front end: capture, x1, divider setup
    // ------------------------------------------------------------------
    logic [15:0] ut_reg;
    logic [18:0] up0_reg, up_a_reg, up_b_reg;
    logic [31:0] prod_a_reg;
    logic [31:0] x1_b_reg, den_b_reg;
    logic [31:0] x1_b_next;
    logic [31:0] num_w, den_mag_next;
    logic [26:0] num_mag_next;

    assign x1_b_next    = bpc_pkg::asr32(prod_a_reg, 5'd15);
    // mc * 2048 always fits in 27 bits of magnitude
    assign num_w        = {mc_w[20:0], 11'd0};
    assign num_mag_next = num_w[31] ? 27'(-num_w) : num_w[26:0];
    assign den_mag_next = den_b_reg[31] ? (-den_b_reg) : den_b_reg;

    // b5 divider stage storage, index 0 is the setup stage
    logic [31:0] d1_rem_reg [0:D1];
    logic [D1-1:0] d1_quo_reg [0:D1];
    logic [31:0] d1_div_reg [0:D1];
    logic [31:0] d1_x1_reg  [0:D1];
    logic [18:0] d1_up_reg  [0:D1];
    logic        d1_neg_reg [0:D1];
    logic        d1_flt_reg [0:D1];
    logic [32:0] d1_trial   [1:D1];
    logic        d1_ge      [1:D1];

    always_comb
    begin
        for (int k = 1; k <= D1; k++)
        begin
            d1_trial[k] = {d1_rem_reg[k-1], d1_quo_reg[k-1][D1-1]};
            d1_ge[k]    = d1_trial[k] >= {1'b0, d1_div_reg[k-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        ut_reg     <= raw_temperature;
        up0_reg    <= raw_pressure;
        prod_a_reg <= ({16'd0, ut_reg} - ac6_w) * ac5_w;
        up_a_reg   <= up0_reg;
        x1_b_reg   <= x1_b_next;
        den_b_reg  <= x1_b_next + md_w;
        up_b_reg   <= up_a_reg;

        d1_rem_reg[0] <= '0;
        d1_quo_reg[0] <= num_mag_next;
        d1_div_reg[0] <= den_mag_next;
        d1_neg_reg[0] <= num_w[31] ^ den_b_reg[31];
        d1_flt_reg[0] <= (den_b_reg == '0);
        d1_x1_reg[0]  <= x1_b_reg;
        d1_up_reg[0]  <= up_b_reg;

        // restoring division, one quotient bit per stage
        for (int k = 1; k <= D1; k++)
        begin
            d1_rem_reg[k] <= d1_ge[k] ? 32'(d1_trial[k] - {1'b0, d1_div_reg[k-1]})
                                      : d1_trial[k][31:0];
            d1_quo_reg[k] <= {d1_quo_reg[k-1][D1-2:0], d1_ge[k]};
            d1_div_reg[k] <= d1_div_reg[k-1];
            d1_neg_reg[k] <= d1_neg_reg[k-1];
            d1_flt_reg[k] <= d1_flt_reg[k-1];
            d1_x1_reg[k]  <= d1_x1_reg[k-1];
            d1_up_reg[k]  <= d1_up_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // b5, temperature and the b3 / b4 / b7 terms
    // ------------------------------------------------------------------
    logic [31:0] x2_d_reg, x1_d_reg;
    logic [18:0] up_d_reg, up_e_reg, up_f_reg, up_g_reg, up_h_reg, up_i_reg;
    logic        flt_d_reg, flt_e_reg, flt_f_reg, flt_g_reg, flt_h_reg;
    logic        flt_i_reg, flt_j_reg, flt_k_reg;
    logic [31:0] temp_e_reg, temp_f_reg, temp_g_reg, temp_h_reg;
    logic [31:0] temp_i_reg, temp_j_reg, temp_k_reg;
    logic [31:0] b6_e_reg;
    logic [31:0] sq_f_reg, ac2b6_f_reg, ac3b6_f_reg;
    logic [31:0] mb2_g_reg, mb1_g_reg, x2_g_reg, x1_g_reg;
    logic [31:0] x3_h_reg, s4_h_reg;
    logic [31:0] b3_i_reg, c_i_reg;
    logic [31:0] b4p_j_reg, diff_j_reg;
    logic [31:0] b4_k_reg, b7_k_reg;
    logic [31:0] q1_w, b5_next, sq_next, b3_sum_next;

    assign q1_w        = {{(32-D1){1'b0}}, d1_quo_reg[D1]};
    assign b5_next     = x1_d_reg + x2_d_reg;
    assign sq_next     = bpc_pkg::asr32(sq_f_reg, 5'd12);
    assign b3_sum_next = ({ac1_w[29:0], 2'b00} + x3_h_reg) << oss_reg;

    always_ff @(posedge clk)
    begin
        // D: signed quotient
        x2_d_reg  <= d1_neg_reg[D1] ? (-q1_w) : q1_w;
        x1_d_reg  <= d1_x1_reg[D1];
        flt_d_reg <= d1_flt_reg[D1];
        up_d_reg  <= d1_up_reg[D1];
        // E: b5, temperature, b6
        temp_e_reg <= bpc_pkg::asr32(b5_next + bpc_pkg::T_ROUND, 5'd4);
        b6_e_reg   <= b5_next - bpc_pkg::B6_OFFSET;
        flt_e_reg  <= flt_d_reg;
        up_e_reg   <= up_d_reg;
        // F: products on b6
        sq_f_reg    <= b6_e_reg * b6_e_reg;
        ac2b6_f_reg <= ac2_w * b6_e_reg;
        ac3b6_f_reg <= ac3_w * b6_e_reg;
        temp_f_reg  <= temp_e_reg;
        flt_f_reg   <= flt_e_reg;
        up_f_reg    <= up_e_reg;
        // G: curve products
        mb2_g_reg  <= b2_w * sq_next;
        mb1_g_reg  <= b1_w * sq_next;
        x2_g_reg   <= bpc_pkg::asr32(ac2b6_f_reg, 5'd11);
        x1_g_reg   <= bpc_pkg::asr32(ac3b6_f_reg, 5'd13);
        temp_g_reg <= temp_f_reg;
        flt_g_reg  <= flt_f_reg;
        up_g_reg   <= up_f_reg;
        // H: partial sums
        x3_h_reg   <= bpc_pkg::asr32(mb2_g_reg, 5'd11) + x2_g_reg;
        s4_h_reg   <= x1_g_reg + bpc_pkg::asr32(mb1_g_reg, 5'd16);
        temp_h_reg <= temp_g_reg;
        flt_h_reg  <= flt_g_reg;
        up_h_reg   <= up_g_reg;
        // I: b3 and the b4 factor
        b3_i_reg   <= bpc_pkg::asr32(b3_sum_next + 32'd2, 5'd2);
        c_i_reg    <= bpc_pkg::asr32(s4_h_reg + 32'd2, 5'd2) + bpc_pkg::C_BIAS;
        temp_i_reg <= temp_h_reg;
        flt_i_reg  <= flt_h_reg;
        up_i_reg   <= up_h_reg;
        // J: b4 product, up - b3
        b4p_j_reg  <= ac4_w * c_i_reg;
        diff_j_reg <= {13'd0, up_i_reg} - b3_i_reg;
        temp_j_reg <= temp_i_reg;
        flt_j_reg  <= flt_i_reg;
        // K: b4, b7, second zero check
        b4_k_reg   <= b4p_j_reg >> 15;
        b7_k_reg   <= diff_j_reg * (bpc_pkg::B7_SCALE >> oss_reg);
        temp_k_reg <= temp_j_reg;
        flt_k_reg  <= flt_j_reg || (b4p_j_reg[31:15] == '0);
    end

    // ------------------------------------------------------------------
    // pressure divider, b7 / b4 with the doubling before or after
    // ------------------------------------------------------------------
    logic [31:0] d2_rem_reg  [0:D2];
    logic [31:0] d2_quo_reg  [0:D2];
    logic [31:0] d2_div_reg  [0:D2];
    logic [31:0] d2_temp_reg [0:D2];
    logic        d2_post_reg [0:D2];
    logic        d2_flt_reg  [0:D2];
    logic [32:0] d2_trial    [1:D2];
    logic        d2_ge       [1:D2];

    always_comb
    begin
        for (int k = 1; k <= D2; k++)
        begin
            d2_trial[k] = {d2_rem_reg[k-1], d2_quo_reg[k-1][D2-1]};
            d2_ge[k]    = d2_trial[k] >= {1'b0, d2_div_reg[k-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        d2_rem_reg[0]  <= '0;
        d2_quo_reg[0]  <= b7_k_reg[31] ? b7_k_reg : {b7_k_reg[30:0], 1'b0};
        d2_post_reg[0] <= b7_k_reg[31];
        d2_div_reg[0]  <= b4_k_reg;
        d2_temp_reg[0] <= temp_k_reg;
        d2_flt_reg[0]  <= flt_k_reg;

        for (int k = 1; k <= D2; k++)
        begin
            d2_rem_reg[k]  <= d2_ge[k] ? 32'(d2_trial[k] - {1'b0, d2_div_reg[k-1]})
                                       : d2_trial[k][31:0];
            d2_quo_reg[k]  <= {d2_quo_reg[k-1][D2-2:0], d2_ge[k]};
            d2_div_reg[k]  <= d2_div_reg[k-1];
            d2_post_reg[k] <= d2_post_reg[k-1];
            d2_temp_reg[k] <= d2_temp_reg[k-1];
            d2_flt_reg[k]  <= d2_flt_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // final pressure correction and result register
    // ------------------------------------------------------------------
    logic [31:0] p_m_reg, p_n_reg, p_o_reg;
    logic [31:0] sqa_n_reg, lin_n_reg, m3_o_reg, x2_o_reg;
    logic [31:0] temp_m_reg, temp_n_reg, temp_o_reg;
    logic        flt_m_reg, flt_n_reg, flt_o_reg;
    logic [31:0] a8_next, comp_next;
    logic [31:0] pressure_reg, temperature_reg;
    logic        fault_reg;

    assign a8_next   = bpc_pkg::asr32(p_m_reg, 5'd8);
    assign comp_next = p_o_reg + bpc_pkg::asr32(bpc_pkg::asr32(m3_o_reg, 5'd16) + x2_o_reg
                                                + bpc_pkg::P_OFFSET, 5'd4);

    always_ff @(posedge clk)
    begin
        p_m_reg    <= d2_post_reg[D2] ? {d2_quo_reg[D2][30:0], 1'b0} : d2_quo_reg[D2];
        temp_m_reg <= d2_temp_reg[D2];
        flt_m_reg  <= d2_flt_reg[D2];

        sqa_n_reg  <= a8_next * a8_next;
        lin_n_reg  <= p_m_reg * bpc_pkg::P_LIN_COEF;
        p_n_reg    <= p_m_reg;
        temp_n_reg <= temp_m_reg;
        flt_n_reg  <= flt_m_reg;

        m3_o_reg   <= sqa_n_reg * bpc_pkg::P_SQ_COEF;
        x2_o_reg   <= bpc_pkg::asr32(lin_n_reg, 5'd16);
        p_o_reg    <= p_n_reg;
        temp_o_reg <= temp_n_reg;
        flt_o_reg  <= flt_n_reg;

        // a zero divisor anywhere forces both results to zero
        pressure_reg    <= flt_o_reg ? '0 : comp_next;
        temperature_reg <= flt_o_reg ? '0 : temp_o_reg;
        fault_reg       <= flt_o_reg;
    end

    assign done               = vld_reg[LAT-1];
    assign pressure_pa        = pressure_reg;
    assign temperature_tenths = temperature_reg;
    assign divide_fault       = fault_reg;

`ifndef SYNTHESIS
    // a result strobe always traces back to an input transfer
    a_done_traced: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result strobe without matching input transfer");

    // a fault result carries zero payload
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divide_fault) |-> (pressure_pa == '0 && temperature_tenths == '0))
        else $error("fault result with nonzero payload");

    // the b5 divider only sees a zero divisor when flagged
    a_div1_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[ST_C] && !d1_flt_reg[0]) |-> (d1_div_reg[0] != '0))
        else $error("b5 divider entered with zero divisor");

    // the pressure divider only sees a zero divisor when flagged
    a_div2_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[ST_L] && !d2_flt_reg[0]) |-> (d2_div_reg[0] != '0))
        else $error("pressure divider entered with zero divisor");
`endif

endmodule

// ===== tb/barometric_pressure_compensation_test.sv =====
`timescale 1ns / 1ps

module barometric_pressure_compensation_test;

    // one compensated reading as it leaves the block
    typedef struct packed {
        logic [31:0] pressure;
        logic [31:0] temperature;
        logic        fault;
    } reading_t;

    // one row of the directed table: coefficient set, readings, and
    // optionally a result typed in by hand
    typedef struct {
        logic [63:0] tc;
        logic [63:0] pc;
        logic [31:0] cc;
        logic [1:0]  oss;
        logic [15:0] ut;
        logic [18:0] up;
        bit          hand;
        reading_t    want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] raw_temperature;
    logic [18:0] raw_pressure;
    logic        done;
    logic [31:0] pressure_pa;
    logic [31:0] temperature_tenths;
    logic        divide_fault;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    // local copy of the coefficient registers
    logic [63:0] temp_coeffs;
    logic [63:0] press_coeffs;
    logic [31:0] curve_coeffs;
    logic [1:0]  oss_mode;

    reading_t    pending_readings[$];
    int          error_count;
    bit          stim_done;

    barometric_pressure_compensation dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .raw_temperature    (raw_temperature),
        .raw_pressure       (raw_pressure),
        .done               (done),
        .pressure_pa        (pressure_pa),
        .temperature_tenths (temperature_tenths),
        .divide_fault       (divide_fault),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // signed 32-bit division truncating toward zero, wrapping the quotient
    function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
        longint qa;
        longint qb;
        qa = longint'($signed(a));
        qb = longint'($signed(b));
        return 32'(qa / qb);
    endfunction

    // sign extend the low 16 bits to a word
    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // compensation of one reading pair under the current coefficients
    function automatic reading_t compensate(input logic [15:0] ut, input logic [18:0] up);
        reading_t    r;
        logic [31:0] ac5, ac6, mc, md, ac1, ac2, ac3, ac4, b1, b2;
        logic [31:0] x1, x2, x3, b5, b6, sq, b3, b4, b7, p, den;
        ac5 = {16'd0, temp_coeffs[63:48]};
        ac6 = {16'd0, temp_coeffs[47:32]};
        mc  = sext16(temp_coeffs[31:16]);
        md  = sext16(temp_coeffs[15:0]);
        ac1 = sext16(press_coeffs[63:48]);
        ac2 = sext16(press_coeffs[47:32]);
        ac3 = sext16(press_coeffs[31:16]);
        ac4 = {16'd0, press_coeffs[15:0]};
        b1  = sext16(curve_coeffs[31:16]);
        b2  = sext16(curve_coeffs[15:0]);
        r = '{pressure: 32'd0, temperature: 32'd0, fault: 1'b1};

        x1  = 32'($signed(({16'd0, ut} - ac6) * ac5) >>> 15);
        den = x1 + md;
        if (den == 32'd0)
            return r;
        x2 = div_trunc(mc * 32'd2048, den);
        b5 = x1 + x2;
        r.temperature = 32'($signed(b5 + 32'd8) >>> 4);

        b6 = b5 - 32'd4000;
        sq = 32'($signed(b6 * b6) >>> 12);
        x1 = 32'($signed(b2 * sq) >>> 11);
        x2 = 32'($signed(ac2 * b6) >>> 11);
        x3 = x1 + x2;
        b3 = 32'($signed(((ac1 * 32'd4 + x3) << oss_mode) + 32'd2) >>> 2);
        x1 = 32'($signed(ac3 * b6) >>> 13);
        x2 = 32'($signed(b1 * sq) >>> 16);
        x3 = 32'($signed(x1 + x2 + 32'd2) >>> 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 32'd0)
        begin
            r.temperature = 32'd0;
            return r;
        end
        b7 = ({13'd0, up} - b3) * (32'd50000 >> oss_mode);
        if (!b7[31])
            p = (b7 << 1) / b4;
        else
            p = (b7 / b4) << 1;

        x1 = 32'($signed(p) >>> 8);
        x1 = x1 * x1;
        x1 = 32'($signed(x1 * 32'd3038) >>> 16);
        x2 = 32'($signed(p * 32'hFFFF_E343) >>> 16);
        r.pressure = p + 32'($signed(x1 + x2 + 32'd3791) >>> 4);
        r.fault = 1'b0;
        return r;
    endfunction

    // single register write, mirrored into the local copy
    task automatic write_reg(input bpc_pkg::cfg_index_t idx, input logic [63:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            bpc_pkg::CFG_TEMP_COEFF:  temp_coeffs  = value;
            bpc_pkg::CFG_PRESS_COEFF: press_coeffs = value;
            bpc_pkg::CFG_CURVE_COEFF: curve_coeffs = value[31:0];
            bpc_pkg::CFG_OSS:         oss_mode     = value[1:0];
            default:                  oss_mode     = oss_mode;
        endcase
    endtask

    // registers change only with the pipeline drained
    task automatic drain();
        start <= 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (bpc_pkg::LATENCY + 4) @(negedge clk);
    endtask

    task automatic load_coeffs(input logic [63:0] tc, input logic [63:0] pc,
                               input logic [31:0] cc, input logic [1:0] oss);
        drain();
        write_reg(bpc_pkg::CFG_TEMP_COEFF, tc);
        write_reg(bpc_pkg::CFG_PRESS_COEFF, pc);
        write_reg(bpc_pkg::CFG_CURVE_COEFF, {32'd0, cc});
        write_reg(bpc_pkg::CFG_OSS, {62'd0, oss});
    endtask

    // idle gap before a transfer: mostly none or short, now and then long
    task automatic sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return;
        start <= 1'b0;
        if (pick < 92)
            repeat ($urandom_range(1, 3)) @(negedge clk);
        else
            repeat ($urandom_range(8, 40)) @(negedge clk);
    endtask

    // one reading pair transfer; the expectation is queued as it is accepted
    task automatic send_reading(input logic [15:0] ut, input logic [18:0] up,
                                input bit hand, input reading_t want);
        sender_gap();
        start           <= 1'b1;
        raw_temperature <= ut;
        raw_pressure    <= up;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_readings.push_back(hand ? want : compensate(ut, up));
        @(negedge clk);
    endtask

    // typical factory coefficients
    localparam logic [63:0] TC_NOMINAL = {16'd32757, 16'd23153, 16'hD4BD, 16'd2868};
    localparam logic [63:0] PC_NOMINAL = {16'd408, 16'hFFCA, 16'hC647, 16'd32741};
    localparam logic [31:0] CC_NOMINAL = {16'd6190, 16'd4};

    // directed table: reset values, extremes, both zero divisor cases
    row_t rows[] = '{
        // after reset all coefficients are zero so the first divisor is zero
        '{64'd0, 64'd0, 32'd0, 2'd1, 16'd0, 19'd0, 1'b1, '{32'd0, 32'd0, 1'b1}},
        '{64'd0, 64'd0, 32'd0, 2'd1, 16'hFFFF, 19'h7FFFF, 1'b1, '{32'd0, 32'd0, 1'b1}},
        // temperature valid, ac4 zero gives a zero b4
        '{TC_NOMINAL, 64'd0, CC_NOMINAL, 2'd0, 16'd27898, 19'd23843, 1'b1,
          '{32'd0, 32'd0, 1'b1}},
        '{TC_NOMINAL, PC_NOMINAL, CC_NOMINAL, 2'd0, 16'd27898, 19'd23843, 1'b0, '0},
        '{TC_NOMINAL, PC_NOMINAL, CC_NOMINAL, 2'd1, 16'd0, 19'd0, 1'b0, '0},
        '{TC_NOMINAL, PC_NOMINAL, CC_NOMINAL, 2'd2, 16'hFFFF, 19'h7FFFF, 1'b0, '0},
        '{TC_NOMINAL, PC_NOMINAL, CC_NOMINAL, 2'd3, 16'h8000, 19'h40000, 1'b0, '0},
        '{TC_NOMINAL, PC_NOMINAL, CC_NOMINAL, 2'd3, 16'h7FFF, 19'h3FFFF, 1'b0, '0},
        // all ones and all signed extremes in every coefficient
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 2'd3,
          16'd0, 19'h7FFFF, 1'b0, '0},
        '{64'hFFFF_FFFF_8000_7FFF, 64'h8000_8000_8000_FFFF, 32'h8000_8000, 2'd0,
          16'hFFFF, 19'd0, 1'b0, '0},
        '{64'hFFFF_0000_7FFF_8000, 64'h7FFF_7FFF_7FFF_FFFF, 32'h7FFF_7FFF, 2'd2,
          16'h1234, 19'h55555, 1'b0, '0},
        // md cancels x1 at ut = ac6 with ac5 arbitrary: x1 zero, md zero
        '{64'h1234_5678_4321_0000, PC_NOMINAL, CC_NOMINAL, 2'd1, 16'h5678, 19'd1000,
          1'b1, '{32'd0, 32'd0, 1'b1}}
    };

    // result side: compare every strobe against the oldest expectation
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && done)
        begin
            if (pending_readings.size() == 0)
            begin
                $display("%0t: unexpected result p=%h t=%h f=%b", $time,
                         pressure_pa, temperature_tenths, divide_fault);
                error_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (pressure_pa !== want.pressure)
                begin
                    $display("%0t: pressure_pa expected %h actual %h", $time,
                             want.pressure, pressure_pa);
                    error_count++;
                end
                if (temperature_tenths !== want.temperature)
                begin
                    $display("%0t: temperature_tenths expected %h actual %h", $time,
                             want.temperature, temperature_tenths);
                    error_count++;
                end
                if (divide_fault !== want.fault)
                begin
                    $display("%0t: divide_fault expected %b actual %b", $time,
                             want.fault, divide_fault);
                    error_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic [63:0] tc;
        logic [63:0] pc;
        logic [31:0] cc;
        int          pick;
        error_count     = 0;
        stim_done       = 1'b0;
        temp_coeffs     = 64'd0;
        press_coeffs    = 64'd0;
        curve_coeffs    = 32'd0;
        oss_mode        = bpc_pkg::OSS_RESET;
        rst_n           = 1'b0;
        start           = 1'b0;
        raw_temperature = 16'd0;
        raw_pressure    = 19'd0;
        cfg_write       = 1'b0;
        cfg_index       = bpc_pkg::CFG_TEMP_COEFF;
        cfg_data        = 64'd0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // the first two rows run on reset values with no write at all
        foreach (rows[i])
        begin
            if (i >= 2)
                load_coeffs(rows[i].tc, rows[i].pc, rows[i].cc, rows[i].oss);
            send_reading(rows[i].ut, rows[i].up, rows[i].hand, rows[i].want);
        end

        // random phases, each under its own coefficient set
        for (int phase = 0; phase < 26; phase++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                // near nominal: realistic readings get through the full path
                tc = {16'(TC_NOMINAL[63:48] + $urandom_range(0, 4000) - 2000),
                      16'(TC_NOMINAL[47:32] + $urandom_range(0, 4000) - 2000),
                      16'(TC_NOMINAL[31:16] + $urandom_range(0, 2000) - 1000),
                      16'(TC_NOMINAL[15:0] + $urandom_range(0, 1000) - 500)};
                pc = {16'(PC_NOMINAL[63:48] + $urandom_range(0, 4000) - 2000),
                      16'(PC_NOMINAL[47:32] + $urandom_range(0, 400) - 200),
                      16'(PC_NOMINAL[31:16] + $urandom_range(0, 4000) - 2000),
                      16'(PC_NOMINAL[15:0] + $urandom_range(0, 4000) - 2000)};
                cc = {16'(CC_NOMINAL[31:16] + $urandom_range(0, 2000) - 1000),
                      16'($urandom_range(0, 64) - 32)};
            end
            else
            begin
                tc = {$urandom, $urandom};
                pc = {$urandom, $urandom};
                cc = $urandom;
                if (pick == 9)
                    pc[15:0] = 16'd0;
            end
            load_coeffs(tc, pc, cc, 2'($urandom_range(0, 3)));
            for (int k = 0; k < 75; k++)
            begin
                if ($urandom_range(0, 3) != 0)
                    send_reading(16'($urandom_range(20000, 36000)),
                                 19'($urandom_range(15000, 200000)), 1'b0, '0);
                else
                    send_reading(16'($urandom), 19'($urandom), 1'b0, '0);
            end
        end
        start <= 1'b0;
        stim_done = 1'b1;
    end

    // end of run: drain the expectations and the pipeline, then the verdict
    initial
    begin
        wait (stim_done);
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (bpc_pkg::LATENCY + 10) @(negedge clk);
        if (error_count == 0 && pending_readings.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/bpc_pkg.sv
rtl/core/barometric_pressure_compensation.sv
tb/barometric_pressure_compensation_test.sv
